// ----- hw/rtl/nsa_pkg.sv -----
package nsa_pkg;

  // defaults for the top-level parameters
  localparam int unsigned TableEntriesDef  = 3;
  localparam int unsigned WindowSamplesDef = 8;

  // fixed field widths
  localparam int unsigned IdW  = 8;
  localparam int unsigned StrW = 16;
  localparam int unsigned EntW = IdW + StrW;

  localparam logic [StrW-1:0] LowSeed = 16'h7fff;
  localparam logic [IdW-1:0]  EmptyId = 8'hff;

  // report carries own reading plus this many table slots
  localparam int unsigned  ReportSlots = 3;
  localparam logic [1:0]   LastSlot    = 2'(ReportSlots - 1);

  localparam logic ActNeighbor = 1'b0;
  localparam logic ActSample   = 1'b1;

  localparam logic KindBcast  = 1'b0;
  localparam logic KindReport = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StBcast,
    StRepOwn,
    StRepTab
  } state_e;

  typedef struct packed {
    logic            kind;
    logic [IdW-1:0]  packet_id;
    logic [IdW-1:0]  node_id_out;
    logic [StrW-1:0] reading;
    logic            last;
  } beat_t;

endpackage

// ----- hw/rtl/nsa_ram.sv -----
module nsa_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 3,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/nsa_ctrl.sv -----
module nsa_ctrl import nsa_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES  = TableEntriesDef,
  parameter int unsigned WINDOW_SAMPLES = WindowSamplesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            action_i,
  input  logic [IdW-1:0]  node_id_i,
  input  logic [StrW-1:0] strength_i,
  input  logic            link_busy_i,
  input  logic [IdW-1:0]  own_id_i,
  input  logic            out_free_i,
  output logic            beat_valid_o,
  output beat_t           beat_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(WINDOW_SAMPLES);
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_ENTRIES - 1);

  state_e state_q, state_d;

  logic [StrW-1:0]          str_q, str_d;
  logic [IdW-1:0]           nid_q, nid_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic [1:0]               slot_q, slot_d;
  logic [StrW-1:0]          low_val_q, low_val_d;
  logic [AW-1:0]            low_place_q, low_place_d;
  logic                     low_set_q, low_set_d;
  logic [StrW-1:0]          val0_q, val0_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [TABLE_ENTRIES-1:0] empty_q, empty_d;
  logic [StrW-1:0]          peak_q, peak_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [IdW-1:0]           rid_q, rid_d;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [EntW-1:0] ram_wdata, ram_rdata;

  logic            acc;
  logic            wend;
  logic            beats_peak;
  logic [CW:0]     cnt_inc;
  logic [IdW-1:0]  ev_id;
  logic [StrW-1:0] ev_val;
  logic [StrW-1:0] cur_low;
  logic            ev_lt;
  logic            ev_match;
  logic [AW-1:0]   new_place;
  logic [StrW-1:0] new_cmp;
  logic            slot_in;
  logic            slot_nxt_in;
  logic [1:0]      slot_nxt;

  nsa_ram #(
    .WIDTH (EntW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entry seen through the reset / clear flags
  function automatic logic [EntW-1:0] view(input logic [EntW-1:0] raw,
                                            input logic vld, input logic emp);
    logic [EntW-1:0] r;
    r = raw;
    if (emp) begin
      r = {EmptyId, {StrW{1'b0}}};
    end else if (!vld) begin
      r = '0;
    end
    return r;
  endfunction

  assign in_ready_o = (state_q == StIdle);
  assign acc        = in_valid_i && in_ready_o;
  assign cnt_inc    = {1'b0, cnt_q} + (CW+1)'(1);
  assign wend       = (cnt_inc == (CW+1)'(WINDOW_SAMPLES));
  assign beats_peak = strength_i > peak_q;

  assign {ev_id, ev_val} = view(ram_rdata, valid_q[idx_q], empty_q[idx_q]);
  assign cur_low   = low_set_q ? low_val_q : LowSeed;
  assign ev_lt     = ev_val < cur_low;
  assign ev_match  = (ev_id == nid_q);
  assign new_place = ev_lt ? idx_q : low_place_q;
  always_comb begin
    if (ev_lt || (!low_set_q && idx_q == '0)) begin
      new_cmp = ev_val;
    end else if (low_set_q) begin
      new_cmp = low_val_q;
    end else begin
      new_cmp = val0_q;
    end
  end

  assign slot_nxt    = slot_q + 2'd1;
  assign slot_in     = (5'(slot_q) < 5'(TABLE_ENTRIES));
  assign slot_nxt_in = (5'(slot_nxt) < 5'(TABLE_ENTRIES));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (acc) begin
          if (action_i == ActNeighbor) begin
            state_d = StScan;
          end else if (!wend) begin
            state_d = StBcast;
          end else if (beats_peak && !link_busy_i) begin
            state_d = StRepOwn;
          end
        end
      end
      StScan: begin
        if (ev_match || idx_q == LastIdx) begin
          state_d = StIdle;
        end
      end
      StBcast: begin
        if (out_free_i) begin
          state_d = StIdle;
        end
      end
      StRepOwn: begin
        if (out_free_i) begin
          state_d = StRepTab;
        end
      end
      StRepTab: begin
        if (out_free_i && slot_q == LastSlot) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    str_d       = str_q;
    nid_d       = nid_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    low_val_d   = low_val_q;
    low_place_d = low_place_q;
    low_set_d   = low_set_q;
    val0_d      = val0_q;
    valid_d     = valid_q;
    empty_d     = empty_q;
    peak_d      = peak_q;
    cnt_d       = cnt_q;
    rid_d       = rid_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = {nid_q, str_q};
    ram_re      = 1'b0;
    ram_raddr   = '0;
    beat_valid_o = 1'b0;
    beat_o       = '{kind: KindBcast, packet_id: '0, node_id_out: own_id_i,
                     reading: str_q, last: 1'b1};
    case (state_q)
      StIdle: begin
        if (acc) begin
          str_d = strength_i;
          nid_d = node_id_i;
          if (action_i == ActNeighbor) begin
            ram_re      = 1'b1;
            idx_d       = '0;
            low_set_d   = 1'b0;
            low_place_d = '0;
            if (beats_peak) begin
              peak_d = strength_i;
            end
          end else if (!wend) begin
            cnt_d = cnt_inc[CW-1:0];
          end else begin
            cnt_d  = '0;
            peak_d = '0;
            if (rid_q == '0) begin
              rid_d = strength_i[IdW-1:0];
            end
            // busy link with a new peak: no report, table still cleared
            if (beats_peak && link_busy_i) begin
              empty_d = '1;
            end
          end
        end
      end
      StScan: begin
        if (ev_lt) begin
          low_val_d   = ev_val;
          low_place_d = idx_q;
          low_set_d   = 1'b1;
        end
        if (idx_q == '0) begin
          val0_d = ev_val;
        end
        if (ev_match) begin
          ram_we         = 1'b1;
          ram_waddr      = idx_q;
          valid_d[idx_q] = 1'b1;
          empty_d[idx_q] = 1'b0;
        end else if (idx_q == LastIdx) begin
          if (new_cmp < str_q) begin
            ram_we             = 1'b1;
            ram_waddr          = new_place;
            valid_d[new_place] = 1'b1;
            empty_d[new_place] = 1'b0;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + AW'(1);
          idx_d     = idx_q + AW'(1);
        end
      end
      StBcast: begin
        beat_valid_o = 1'b1;
      end
      StRepOwn: begin
        beat_valid_o = 1'b1;
        beat_o.kind      = KindReport;
        beat_o.packet_id = rid_q;
        beat_o.last      = 1'b0;
        if (out_free_i) begin
          slot_d    = '0;
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
      end
      StRepTab: begin
        beat_valid_o = 1'b1;
        beat_o.kind      = KindReport;
        beat_o.packet_id = rid_q;
        beat_o.last      = (slot_q == LastSlot);
        if (slot_in) begin
          {beat_o.node_id_out, beat_o.reading} =
            view(ram_rdata, valid_q[AW'(slot_q)], empty_q[AW'(slot_q)]);
        end else begin
          beat_o.node_id_out = EmptyId;
          beat_o.reading     = '0;
        end
        if (out_free_i) begin
          if (slot_q == LastSlot) begin
            empty_d = '1;
            rid_d   = rid_q + IdW'(1);
          end else begin
            slot_d = slot_nxt;
            if (slot_nxt_in) begin
              ram_re    = 1'b1;
              ram_raddr = AW'(slot_nxt);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      valid_q   <= '0;
      empty_q   <= '0;
      peak_q    <= '0;
      cnt_q     <= '0;
      rid_q     <= '0;
      low_set_q <= 1'b0;
      idx_q     <= '0;
      slot_q    <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      empty_q   <= empty_d;
      peak_q    <= peak_d;
      cnt_q     <= cnt_d;
      rid_q     <= rid_d;
      low_set_q <= low_set_d;
      idx_q     <= idx_d;
      slot_q    <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    str_q       <= str_d;
    nid_q       <= nid_d;
    low_val_q   <= low_val_d;
    low_place_q <= low_place_d;
    val0_q      <= val0_d;
  end

endmodule

// ----- hw/rtl/neighbor_strength_aggregator.sv -----
// channel   | dir | beat handshake        | contents
// ----------+-----+-----------------------+-----------------------------------------
// s_*       | in  | s_tvalid_i/s_tready_o | tuser: action; tdata: node/strength/busy
// m_*       | out | m_tvalid_o/m_tready_i | tuser: kind; tdata: pid/node/reading
// cfg_*     | in  | cfg_valid_i/cfg_ready_o | own_id, always ready
//
// One item at a time; the single table RAM read port sets the pace.
// Neighbor reading: entries are scanned in order until a match or the last entry.
// Window sample: a broadcast beat before the window end; at the end, a 4-beat report or no result.
// Output stalls hold the current state while a result beat finds the output register
// full; a result waiting in the output register does not hold off the next input beat.
// Reset: async active low, table flags, peak, count, report id all cleared; no sweep.
module neighbor_strength_aggregator import nsa_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES  = TableEntriesDef,
  parameter int unsigned WINDOW_SAMPLES = WindowSamplesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // [7:0] node_id, [23:8] strength, [24] link_busy
  input  logic        s_tuser_i,   // [0] action
  // result beats
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // [7:0] packet_id, [15:8] node_id_out, [31:16] reading
  output logic        m_tuser_o,   // [0] kind
  output logic        m_tlast_o,
  // own_id write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic [IdW-1:0] own_id_q;
  logic           out_valid_q;
  beat_t          out_q;
  logic           out_free;
  logic           beat_valid;
  beat_t          beat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
    end else if (cfg_valid_i) begin
      own_id_q <= cfg_data_i;
    end
  end

  // output register free when empty or being drained this cycle
  assign out_free = !out_valid_q || m_tready_i;

  nsa_ctrl #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_tvalid_i),
    .in_ready_o   (s_tready_o),
    .action_i     (s_tuser_i),
    .node_id_i    (s_tdata_i[7:0]),
    .strength_i   (s_tdata_i[23:8]),
    .link_busy_i  (s_tdata_i[24]),
    .own_id_i     (own_id_q),
    .out_free_i   (out_free),
    .beat_valid_o (beat_valid),
    .beat_o       (beat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= beat_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && beat_valid) begin
      out_q <= beat;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_q.reading, out_q.node_id_out, out_q.packet_id};
  assign m_tuser_o  = out_q.kind;
  assign m_tlast_o  = out_q.last;

endmodule

// ----- hw/rtl/nsa_checker.sv -----
module nsa_checker import nsa_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic        s_tuser_i,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [31:0] m_tdata_o,
  input logic        m_tuser_o,
  input logic        m_tlast_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o)
      && $stable(m_tlast_o) && $stable(m_tuser_o))
    else $error("result beat changed under stall");

  // broadcast is always a single-beat run
  a_bcast_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o == KindBcast) |-> m_tlast_o)
    else $error("broadcast beat without tlast");

  // no input taken while a report run is still open
  a_report_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (m_tuser_o == KindReport) && !m_tlast_o |-> !s_tready_o)
    else $error("input accepted inside report run");

  // a taken neighbor reading always starts a table scan that holds input ready low
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o && (s_tuser_i == ActNeighbor) |=> !s_tready_o)
    else $error("ready during table scan");

endmodule

bind neighbor_strength_aggregator nsa_checker u_nsa_checker (.*);
